// ----- src/rmmc_pkg.sv -----
// ----------------------------------------------------------------------------
// rmmc_pkg: shared types and constants
// Operation codes, status codes, controller states and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rmmc_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam int CountWidth = 7;

    typedef enum logic [1:0] {
        KIND_ADD      = 2'd0,
        KIND_FINALIZE = 2'd1,
        KIND_QUERY    = 2'd2,
        KIND_CLEAR    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_ZERO = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_NEXT,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_MERGE_RD,
        ST_MERGE_STEP,
        ST_MERGE_DONE,
        ST_QUERY_RD,
        ST_QUERY_CMP,
        ST_QUERY_FIN,
        ST_QUERY_END
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // Latch the incoming transaction.
        logic do_add;      // Store the latched range.
        logic do_clear;    // Empty the set.
        logic sort_init;   // Load the key at index i, set j to i.
        logic sort_rd;     // Read the entry at j - 1.
        logic sort_shift;  // Move entry j - 1 up to j, decrement j.
        logic sort_place;  // Write the key at j, advance i.
        logic merge_init;  // Reset the read and write pointers.
        logic merge_rd;    // Read the entry at the read pointer.
        logic merge_step;  // Fold or append the entry just read.
        logic merge_done;  // Commit the merged count, set the flag.
        logic query_init;  // Set lo and hi for the search.
        logic query_rd;    // Read the start at mid.
        logic query_cmp;   // Narrow the search.
        logic query_fin;   // Read the end at lo - 1.
        logic respond;     // Drive the result strobe.
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  merged;
        logic  count_zero;
        logic  sort_more;  // i is still below the count.
        logic  j_zero;
        logic  goes_first; // The key sorts before entry j - 1.
        logic  merge_more; // The read pointer is below the count.
        logic  search_more;
    } stat_t;

endpackage

// ----- src/rmmc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rmmc_ctrl: operation sequencer
// Steps the datapath through add, clear, insertion sort, merge and search.
// ----------------------------------------------------------------------------
module rmmc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rmmc_pkg::stat_t st,
    output rmmc_pkg::cmd_t  cmd
);
    import rmmc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next = ST_SORT_NEXT;
                end
            end
            ST_SORT_NEXT:
            begin
                // Entered right after capture, this state decodes the operation.
                unique case (st.kind)
                    KIND_ADD:
                    begin
                        cmd.do_add = 1'b1;
                        cmd.respond = 1'b1;
                        state_next = ST_IDLE;
                    end
                    KIND_CLEAR:
                    begin
                        cmd.do_clear = 1'b1;
                        cmd.respond = 1'b1;
                        state_next = ST_IDLE;
                    end
                    KIND_QUERY:
                    begin
                        if (!st.merged || st.count_zero)
                        begin
                            cmd.respond = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.query_init = 1'b1;
                            state_next = ST_QUERY_RD;
                        end
                    end
                    default:
                    begin
                        if (st.merged)
                        begin
                            cmd.respond = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if (st.sort_more)
                        begin
                            cmd.sort_init = 1'b1;
                            state_next = ST_SORT_RD;
                        end
                        else
                        begin
                            cmd.merge_init = 1'b1;
                            state_next = ST_MERGE_RD;
                        end
                    end
                endcase
            end
            ST_SORT_RD:
            begin
                if (st.j_zero)
                begin
                    cmd.sort_place = 1'b1;
                    state_next = ST_SORT_CMP;
                end
                else
                begin
                    cmd.sort_rd = 1'b1;
                    state_next = ST_SORT_CMP;
                end
            end
            ST_SORT_CMP:
            begin
                // Arrived here either after a place (j was zero) or a read.
                if (st.j_zero && !st.goes_first)
                begin
                    state_next = ST_MERGE_DONE;
                end
                else if (st.goes_first)
                begin
                    cmd.sort_shift = 1'b1;
                    state_next = ST_SORT_RD;
                end
                else
                begin
                    cmd.sort_place = 1'b1;
                    state_next = ST_MERGE_DONE;
                end
            end
            ST_MERGE_DONE:
            begin
                // Between sort passes: start the next key or begin merging.
                if (st.sort_more)
                begin
                    cmd.sort_init = 1'b1;
                    state_next = ST_SORT_RD;
                end
                else
                begin
                    cmd.merge_init = 1'b1;
                    state_next = ST_MERGE_RD;
                end
            end
            ST_MERGE_RD:
            begin
                if (st.merge_more)
                begin
                    cmd.merge_rd = 1'b1;
                    state_next = ST_MERGE_STEP;
                end
                else
                begin
                    cmd.merge_done = 1'b1;
                    cmd.respond = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MERGE_STEP:
            begin
                cmd.merge_step = 1'b1;
                state_next = ST_MERGE_RD;
            end
            ST_QUERY_RD:
            begin
                if (st.search_more)
                begin
                    cmd.query_rd = 1'b1;
                    state_next = ST_QUERY_CMP;
                end
                else
                begin
                    cmd.query_fin = 1'b1;
                    state_next = ST_QUERY_FIN;
                end
            end
            ST_QUERY_CMP:
            begin
                cmd.query_cmp = 1'b1;
                state_next = ST_QUERY_RD;
            end
            ST_QUERY_FIN:
            begin
                // Keep the read address at lo - 1 so its end stays on the read data.
                cmd.query_fin = 1'b1;
                state_next = ST_QUERY_END;
            end
            ST_QUERY_END:
            begin
                cmd.respond = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/rmmc_datapath.sv -----
// ----------------------------------------------------------------------------
// rmmc_datapath: range store and arithmetic
// Holds the start and end memories, the count, the finalized flag and the
// pointers used by the sort, merge and search sequences.
// ----------------------------------------------------------------------------
module rmmc_datapath #(
    parameter int CAPACITY = rmmc_pkg::CAPACITY_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [1:0]                          kind,
    input  logic [31:0]                         address,
    input  logic [31:0]                         range_length,
    input  rmmc_pkg::cmd_t                      cmd,
    output rmmc_pkg::stat_t                     st,
    output logic                                done,
    output logic [1:0]                          status,
    output logic                                covered,
    output logic [rmmc_pkg::CountWidth-1:0]     range_count
);
    import rmmc_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0] start_mem [CAPACITY];
    logic [31:0] end_mem [CAPACITY];

    kind_t       kind_reg;
    logic [31:0] addr_reg;
    logic [31:0] len_reg;
    logic [CW-1:0] count_reg;
    logic        merged_reg;

    logic [CW-1:0] i_reg, j_reg, rd_reg, wr_reg, lo_reg, hi_reg;
    logic [31:0] key_s_reg, key_e_reg;
    logic [31:0] rs_reg, re_reg;      // Registered memory read data.
    logic [31:0] last_e_reg;          // End of the entry at wr - 1.
    logic        first_reg;           // Set once the entry at j - 1 is read for the sort compare.
    logic        done_reg, cov_reg;
    logic [1:0]  status_reg;

    logic [AW-1:0] wa, ra;
    logic [31:0]   wds, wde;
    logic          we;
    logic [32:0]   end_sum;
    logic [31:0]   end_sat;
    logic [CW-1:0] mid;

    assign end_sum = {1'b0, addr_reg} + {1'b0, len_reg};
    assign end_sat = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // Write port selection.
    always_comb
    begin
        we = 1'b0;
        wa = count_reg[AW-1:0];
        wds = addr_reg;
        wde = end_sat;
        if (cmd.do_add && len_reg != '0 && count_reg < CW'(CAPACITY))
        begin
            we = 1'b1;
        end
        else if (cmd.sort_shift)
        begin
            we = 1'b1;
            wa = j_reg[AW-1:0];
            wds = rs_reg;
            wde = re_reg;
        end
        else if (cmd.sort_place)
        begin
            we = 1'b1;
            wa = j_reg[AW-1:0];
            wds = key_s_reg;
            wde = key_e_reg;
        end
        else if (cmd.merge_step && !(wr_reg != '0 && rs_reg <= last_e_reg))
        begin
            we = 1'b1;
            wa = wr_reg[AW-1:0];
            wds = rs_reg;
            wde = re_reg;
        end
        else if (cmd.merge_step && re_reg > last_e_reg)
        begin
            we = 1'b1;
            wa = AW'(wr_reg - 1'b1);
            wds = rs_reg;
            wde = re_reg;
        end
    end

    // The fold case rewrites only the end; the start write keeps its value.
    logic        fold_wr;
    assign fold_wr = cmd.merge_step && wr_reg != '0 && rs_reg <= last_e_reg;

    // Read address selection.
    always_comb
    begin
        ra = AW'(j_reg - 1'b1);
        if (cmd.sort_init)
        begin
            ra = i_reg[AW-1:0];
        end
        else if (cmd.merge_rd)
        begin
            ra = rd_reg[AW-1:0];
        end
        else if (cmd.query_rd)
        begin
            ra = mid[AW-1:0];
        end
        else if (cmd.query_fin)
        begin
            ra = AW'(lo_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            if (!fold_wr)
            begin
                start_mem[wa] <= wds;
            end
            end_mem[wa] <= wde;
        end
        rs_reg <= start_mem[ra];
        re_reg <= end_mem[ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(kind);
            addr_reg <= address;
            len_reg <= range_length;
        end
    end

    logic first_cmp;
    assign first_cmp = (key_s_reg != rs_reg) ? (key_s_reg < rs_reg) : (key_e_reg < re_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            merged_reg <= 1'b0;
            i_reg <= CW'(1);
            j_reg <= '0;
            rd_reg <= '0;
            wr_reg <= '0;
            lo_reg <= '0;
            hi_reg <= '0;
            last_e_reg <= '0;
            first_reg <= 1'b0;
            done_reg <= 1'b0;
            cov_reg <= 1'b0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            done_reg <= cmd.respond;
            if (cmd.capture)
            begin
                i_reg <= CW'(1);
                cov_reg <= 1'b0;
                status_reg <= STATUS_OK;
                first_reg <= 1'b0;
            end
            if (cmd.do_add)
            begin
                if (len_reg == '0)
                begin
                    status_reg <= STATUS_ZERO;
                end
                else if (count_reg >= CW'(CAPACITY))
                begin
                    status_reg <= STATUS_FULL;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                    merged_reg <= 1'b0;
                end
            end
            if (cmd.do_clear)
            begin
                count_reg <= '0;
                merged_reg <= 1'b0;
            end
            if (cmd.sort_init)
            begin
                j_reg <= i_reg;
                first_reg <= 1'b0;
            end
            if (cmd.sort_rd)
            begin
                // On the first read of a pass the key is latched from the sort_init read as this flag is set.
                first_reg <= 1'b1;
            end
            if (cmd.sort_shift)
            begin
                j_reg <= j_reg - 1'b1;
                first_reg <= 1'b0;
            end
            if (cmd.sort_place)
            begin
                i_reg <= i_reg + 1'b1;
                first_reg <= 1'b0;
            end
            if (cmd.merge_init)
            begin
                rd_reg <= '0;
                wr_reg <= '0;
            end
            if (cmd.merge_rd)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (cmd.merge_step)
            begin
                if (fold_wr)
                begin
                    if (re_reg > last_e_reg)
                    begin
                        last_e_reg <= re_reg;
                    end
                end
                else
                begin
                    wr_reg <= wr_reg + 1'b1;
                    last_e_reg <= re_reg;
                end
            end
            if (cmd.merge_done)
            begin
                count_reg <= wr_reg;
                merged_reg <= 1'b1;
            end
            if (cmd.query_init)
            begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end
            if (cmd.query_cmp)
            begin
                if (rs_reg <= addr_reg)
                begin
                    lo_reg <= mid + 1'b1;
                end
                else
                begin
                    hi_reg <= mid;
                end
            end
            if (kind_reg == KIND_QUERY && done_reg == 1'b0 && cmd.respond
                && merged_reg && count_reg != '0)
            begin
                cov_reg <= (lo_reg != '0) && (addr_reg < re_reg);
            end
        end
    end

    // The key is taken from the read data in the cycle after sort_init, while key_load_reg is high.
    logic key_load_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_load_reg <= 1'b0;
        end
        else
        begin
            key_load_reg <= cmd.sort_init;
        end
    end
    always_ff @(posedge clk)
    begin
        if (key_load_reg)
        begin
            key_s_reg <= rs_reg;
            key_e_reg <= re_reg;
        end
    end

    assign st.kind = kind_reg;
    assign st.merged = merged_reg;
    assign st.count_zero = (count_reg == '0);
    assign st.sort_more = (i_reg < count_reg);
    assign st.j_zero = (j_reg == '0);
    assign st.goes_first = first_reg && first_cmp && !key_load_reg;
    assign st.merge_more = (rd_reg < count_reg);
    assign st.search_more = (lo_reg < hi_reg);

    assign done = done_reg;
    assign status = status_reg;
    assign covered = cov_reg;
    assign range_count = CountWidth'(count_reg);

endmodule

// ----- src/range_mask_merge_and_cover.sv -----
// ----------------------------------------------------------------------------
// range_mask_merge_and_cover: address range set with merge and lookup
// Stores address ranges, merges them on finalize and answers coverage
// queries by binary search.
// ----------------------------------------------------------------------------
// Usage: drive kind, address and range_length with start high while busy is
// low; that edge accepts the transaction. Exactly one result follows, shown
// on status, covered and range_count for one cycle while done is high. The
// receiver cannot stall, so results must be taken as they appear.
// Add and clear answer straight from the decode state, as does a query on an
// empty or unfinalized set; a search over n merged ranges is bounded by the
// shared memory read port that each binary search step uses. Finalize runs
// an insertion sort that shifts larger entries up one position at a time,
// then a merge pass that folds or appends each entry in turn.
// One transaction is in flight at a time; busy stays high until the cycle
// the result strobe is shown, and a new transaction may be accepted there.
// Reset clears the count and the finalized flag; the range memories are not
// cleared, as only entries below the count are ever used.
// ----------------------------------------------------------------------------
module range_mask_merge_and_cover #(
    parameter int CAPACITY = rmmc_pkg::CAPACITY_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      kind,
    input  logic [31:0]                     address,
    input  logic [31:0]                     range_length,
    output logic                            done,
    output logic [1:0]                      status,
    output logic                            covered,
    output logic [rmmc_pkg::CountWidth-1:0] range_count
);
    import rmmc_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic  ctrl_busy;

    rmmc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (ctrl_busy),
        .st    (st),
        .cmd   (cmd)
    );

    rmmc_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .kind         (kind),
        .address      (address),
        .range_length (range_length),
        .cmd          (cmd),
        .st           (st),
        .done         (done),
        .status       (status),
        .covered      (covered),
        .range_count  (range_count)
    );

    // The controller accepts exactly when it is idle, which includes the
    // result cycle.
    assign busy = ctrl_busy;

endmodule

// ----- src/rmmc_checker.sv -----
// ----------------------------------------------------------------------------
// rmmc_checker: port level checks
// Watches the handshake and result ports of the top level.
// ----------------------------------------------------------------------------
module rmmc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status,
    input logic       covered
);
    import rmmc_pkg::*;

    // An accepted transaction makes the block busy on the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after accept");

    // A result strobe is a pulse and is never held high.
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for two cycles");

    // A result is never shown without a transaction in progress.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without transaction");

    // A covered answer only comes with an ok status.
    a_cov: assert property (@(posedge clk) disable iff (!rst_n)
        (done && covered) |-> (status == STATUS_OK))
        else $error("covered with error status");

endmodule

bind range_mask_merge_and_cover rmmc_checker u_rmmc_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .status  (status),
    .covered (covered)
);
